// ===== rtl/dbam_pkg.sv =====
// ----------------------------------------------------------------------------
// dbam_pkg
// Shared types and constants for the disk block allocation map.
// ----------------------------------------------------------------------------
package dbam_pkg;

    localparam int NUM_TRACKS_DEF  = 35;
    localparam int MAX_SECTORS_DEF = 24;
    localparam int INTERLEAVE_DEF  = 10;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_MARK  = 3'd3;
    localparam logic [2:0] OP_FIND  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] REG_DIR = 3'd0;
    localparam logic [2:0] REG_Z1L = 3'd1;
    localparam logic [2:0] REG_Z2L = 3'd2;
    localparam logic [2:0] REG_Z3L = 3'd3;
    localparam logic [2:0] REG_Z1S = 3'd4;
    localparam logic [2:0] REG_Z2S = 3'd5;
    localparam logic [2:0] REG_Z3S = 3'd6;
    localparam logic [2:0] REG_Z4S = 3'd7;

    // register values after reset
    localparam logic [5:0] DIR_RST = 6'd18;
    localparam logic [5:0] Z1L_RST = 6'd17;
    localparam logic [5:0] Z2L_RST = 6'd24;
    localparam logic [5:0] Z3L_RST = 6'd30;
    localparam logic [4:0] Z1S_RST = 5'd21;
    localparam logic [4:0] Z2S_RST = 5'd19;
    localparam logic [4:0] Z3S_RST = 5'd18;
    localparam logic [4:0] Z4S_RST = 5'd17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD,
        S_RDW,
        S_EXEC,
        S_PROBE,
        S_STEP,
        S_DIR,
        S_OUT
    } state_t;

endpackage

// ===== rtl/disk_block_allocation_map.sv =====
// ----------------------------------------------------------------------------
// disk_block_allocation_map
// Per-track free-sector bitmap and free count with a sequenced free search.
// ----------------------------------------------------------------------------
// Commands enter as s_axis beats (one per operation) and each gives exactly
// one m_axis result beat. The block takes one command at a time: s_axis_tready
// is low from acceptance until its result has been taken.
// Load, read and mark pass through a registered map read, one update step,
// then the result register. Find walks the tracks through the shared track
// read port and a single sector scanner that tests one bit per cycle from
// the start sector, wrapping once, on each track that it probes.
// Clear sweeps the map one track per cycle, over all NUM_TRACKS+1 entries.
// Reset runs the same sweep; s_axis_tready stays low during it while
// configuration writes are still taken. Reset restores the register
// defaults. A stalled result holds in the output register.
// Configuration writes use cfg_we/cfg_index/cfg_data and must come while idle.
// ----------------------------------------------------------------------------
module disk_block_allocation_map
    import dbam_pkg::*;
#(
    parameter int NUM_TRACKS  = NUM_TRACKS_DEF,
    parameter int MAX_SECTORS = MAX_SECTORS_DEF,
    parameter int INTERLEAVE  = INTERLEAVE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], track[8:3], sector[13:9], mark_free[14],
    // track_bitmap[38:15], free_count_in[46:39], zero pad [47]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], found_track[7:2], found_sector[12:8], bitmap_out[36:13],
    // free_count_out[44:37], zero pad [47:45]
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int TW = $clog2(NUM_TRACKS + 1);
    localparam int SW = $clog2(MAX_SECTORS + 1);
    localparam int DEPTH = NUM_TRACKS + 1;
    localparam logic [5:0] NT6 = 6'(NUM_TRACKS);
    localparam logic [5:0] MS6 = 6'(MAX_SECTORS);

    // configuration
    logic [5:0] dir_reg, z1l_reg, z2l_reg, z3l_reg;
    logic [4:0] z1s_reg, z2s_reg, z3s_reg, z4s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_RST; z1l_reg <= Z1L_RST; z2l_reg <= Z2L_RST; z3l_reg <= Z3L_RST;
            z1s_reg <= Z1S_RST; z2s_reg <= Z2S_RST; z3s_reg <= Z3S_RST; z4s_reg <= Z4S_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIR: dir_reg <= cfg_data;
                REG_Z1L: z1l_reg <= cfg_data;
                REG_Z2L: z2l_reg <= cfg_data;
                REG_Z3L: z3l_reg <= cfg_data;
                REG_Z1S: z1s_reg <= cfg_data[4:0];
                REG_Z2S: z2s_reg <= cfg_data[4:0];
                REG_Z3S: z3s_reg <= cfg_data[4:0];
                REG_Z4S: z4s_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    function automatic logic [5:0] range_of(input logic [6:0] t,
        input logic [5:0] l1, input logic [5:0] l2, input logic [5:0] l3,
        input logic [4:0] s1, input logic [4:0] s2, input logic [4:0] s3,
        input logic [4:0] s4);
        logic [5:0] r;
        if (t <= {1'b0, l1})      r = {1'b0, s1};
        else if (t <= {1'b0, l2}) r = {1'b0, s2};
        else if (t <= {1'b0, l3}) r = {1'b0, s3};
        else                      r = {1'b0, s4};
        return (r > MS6) ? MS6 : r;
    endfunction

    // memory
    logic [MAX_SECTORS-1:0] map_mem [DEPTH];
    logic [7:0]             cnt_mem [DEPTH];
    logic                   mem_we;
    logic [TW-1:0]          mem_waddr, mem_raddr;
    logic [MAX_SECTORS-1:0] mem_wmap, rd_map;
    logic [7:0]             mem_wcnt, rd_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wmap;
            cnt_mem[mem_waddr] <= mem_wcnt;
        end
        rd_map <= map_mem[mem_raddr];
        rd_cnt <= cnt_mem[mem_raddr];
    end

    state_t state_reg, state_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [2:0] op_reg, op_next;
    logic [6:0] trk_reg, trk_next;         // signed-ish search track, 0..127, bit 6 set after a step below 0
    logic [SW-1:0] sec_reg, sec_next;
    logic mfree_reg, mfree_next;
    logic [MAX_SECTORS-1:0] bm_reg, bm_next;
    logic [7:0] cin_reg, cin_next;
    logic first_reg, first_next, down_reg, down_next, wrap_reg, wrap_next;
    logic [6:0] move_reg, move_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic pass2_reg, pass2_next;
    logic [5:0] rng_reg, rng_next;
    logic [47:0] out_reg, out_next;
    logic ov_reg, ov_next;

    logic [6:0] d7, clr7;
    logic [5:0] clr_rng, in_trk;
    logic t_ok, clr_dflt;
    assign d7 = {1'b0, dir_reg};
    assign clr7 = {{(7-TW){1'b0}}, clr_reg};
    // the sweep after reset uses the default zone table, a clear the live one
    assign clr_dflt = (op_reg != OP_CLEAR);
    assign clr_rng = clr_dflt ?
        range_of(clr7, Z1L_RST, Z2L_RST, Z3L_RST, Z1S_RST, Z2S_RST, Z3S_RST, Z4S_RST) :
        range_of(clr7, z1l_reg, z2l_reg, z3l_reg, z1s_reg, z2s_reg, z3s_reg, z4s_reg);
    assign in_trk = s_axis_tdata[8:3];
    assign t_ok = (trk_reg >= 7'd1) && (trk_reg <= {1'b0, NT6});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            op_reg    <= OP_READ;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trk_reg <= trk_next; sec_reg <= sec_next;
        mfree_reg <= mfree_next; bm_reg <= bm_next; cin_reg <= cin_next;
        first_reg <= first_next; down_reg <= down_next; wrap_reg <= wrap_next;
        move_reg <= move_next; idx_reg <= idx_next; pass2_reg <= pass2_next;
        rng_reg <= rng_next; out_reg <= out_next;
    end

    function automatic logic [47:0] pack_out(input logic [1:0] st,
        input logic [5:0] ft, input logic [4:0] fs,
        input logic [MAX_SECTORS-1:0] b, input logic [7:0] c);
        logic [23:0] b24;
        b24 = 24'(b);
        return {3'b000, c, b24, fs, ft, st};
    endfunction

    always_comb
    begin
        logic [6:0] nt;
        logic [5:0] srng;
        logic [6:0] s7;
        logic nd, nw, stop;
        state_next = state_reg; clr_next = clr_reg;
        op_next = op_reg; trk_next = trk_reg; sec_next = sec_reg;
        mfree_next = mfree_reg; bm_next = bm_reg; cin_next = cin_reg;
        first_next = first_reg; down_next = down_reg; wrap_next = wrap_reg;
        move_next = move_reg; idx_next = idx_reg; pass2_next = pass2_reg;
        rng_next = rng_reg; out_next = out_reg; ov_next = ov_reg;
        mem_we = 1'b0; mem_waddr = trk_reg[TW-1:0]; mem_raddr = trk_reg[TW-1:0];
        mem_wmap = rd_map; mem_wcnt = rd_cnt;
        s_axis_tready = 1'b0;
        nt = trk_reg; nd = down_reg; nw = wrap_reg; stop = 1'b0;
        srng = '0; s7 = '0;
        if (ov_reg && m_axis_tready) ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = !ov_reg;
                if (s_axis_tvalid && !ov_reg)
                begin
                    op_next = s_axis_tdata[2:0];
                    trk_next = {1'b0, in_trk};
                    sec_next = SW'(s_axis_tdata[13:9]);
                    mfree_next = s_axis_tdata[14];
                    bm_next = s_axis_tdata[15 +: MAX_SECTORS];
                    cin_next = s_axis_tdata[46:39];
                    out_next = '0;
                    priority if (s_axis_tdata[2:0] == OP_CLEAR)
                    begin
                        clr_next = '0;
                        state_next = S_CLEAR;
                    end
                    else if (s_axis_tdata[2:0] == OP_FIND)
                    begin
                        if (in_trk > NT6)
                        begin
                            out_next = pack_out(ST_RANGE, '0, '0, '0, '0);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            // set up search start
                            first_next = (in_trk == 6'd0);
                            nt = (in_trk == 6'd0) ? d7 - 7'd1 : {1'b0, in_trk};
                            trk_next = nt;
                            down_next = (nt < d7);
                            move_next = (nt < d7) ? d7 - nt : nt - d7;
                            wrap_next = 1'b0;
                            srng = range_of(nt, z1l_reg, z2l_reg, z3l_reg,
                                z1s_reg, z2s_reg, z3s_reg, z4s_reg);
                            s7 = {2'b00, s_axis_tdata[13:9]} +
                                ((in_trk == 6'd0) ? 7'd0 : 7'(INTERLEAVE));
                            sec_next = (s7 >= {1'b0, srng}) ? '0 : SW'(s7);
                            state_next = S_RD;
                        end
                    end
                    else if (s_axis_tdata[2:0] == OP_LOAD || s_axis_tdata[2:0] == OP_READ
                             || s_axis_tdata[2:0] == OP_MARK)
                    begin
                        if (in_trk == 6'd0 || in_trk > NT6 ||
                            (s_axis_tdata[2:0] == OP_MARK &&
                             {1'b0, s_axis_tdata[13:9]} >= MS6))
                        begin
                            out_next = pack_out(ST_RANGE, '0, '0, '0, '0);
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_RD;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1; mem_waddr = clr_reg;
                mem_wmap = MAX_SECTORS'((64'd1 << clr_rng) - 64'd1);
                mem_wcnt = {2'b00, clr_rng};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TW'(NUM_TRACKS))
                    state_next = (op_reg == OP_CLEAR) ? S_OUT : S_IDLE;
            end
            S_RD:
            begin
                // a start track off the disk goes straight to the directory try
                if (op_reg == OP_FIND && !t_ok)
                begin
                    trk_next = d7; first_next = 1'b0; op_next = OP_READ;
                    state_next = S_DIR;
                end
                else
                    state_next = S_RDW;
                rng_next = range_of(trk_reg, z1l_reg, z2l_reg, z3l_reg,
                    z1s_reg, z2s_reg, z3s_reg, z4s_reg);
            end
            S_RDW:
            begin
                idx_next = sec_reg; pass2_next = 1'b0;
                if (op_reg == OP_FIND)
                    state_next = ({1'b0, sec_reg} >= 6'(rng_reg)) ? S_STEP : S_PROBE;
                else
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                mem_wmap = rd_map; mem_wcnt = rd_cnt;
                if (op_reg == OP_LOAD)
                begin
                    mem_wmap = bm_reg; mem_wcnt = cin_reg;
                end
                else if (op_reg == OP_MARK)
                begin
                    if (rd_map[sec_reg[SW-1:0]] && !mfree_reg && rd_cnt != 8'd0)
                        mem_wcnt = rd_cnt - 8'd1;
                    if (!rd_map[sec_reg[SW-1:0]] && mfree_reg && rd_cnt != 8'hFF)
                        mem_wcnt = rd_cnt + 8'd1;
                    mem_wmap[sec_reg[SW-1:0]] = mfree_reg;
                end
                mem_we = (op_reg != OP_READ);
                out_next = pack_out(ST_OK, '0, '0, mem_wmap, mem_wcnt);
                state_next = S_OUT;
            end
            S_PROBE:
            begin
                // one sector tested per cycle
                if (rd_map[idx_reg])
                begin
                    out_next = pack_out(ST_OK, trk_reg[5:0], 5'(idx_reg), rd_map, rd_cnt);
                    state_next = S_OUT;
                end
                else if ({1'b0, idx_reg} + 6'd1 >= 6'(rng_reg))
                begin
                    if (pass2_reg) state_next = S_STEP;
                    else begin idx_next = '0; pass2_next = 1'b1; end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_STEP:
            begin
                sec_next = '0;
                if (first_reg)
                begin
                    if (down_reg)
                    begin
                        nd = 1'b0; nt = trk_reg + move_reg;
                        if (nt == d7) nt = nt + 7'd1;
                    end
                    else
                    begin
                        nd = 1'b1; nt = trk_reg - move_reg;
                        if (nt == d7) nt = nt - 7'd1;
                    end
                    if (nt == 7'd0 || nt[6] || nt > {1'b0, NT6}) stop = 1'b1;
                    move_next = move_reg + 7'd1;
                end
                else
                begin
                    if (down_reg)
                    begin
                        nt = trk_reg - 7'd1;
                        if (nt == d7) nt = nt - 7'd1;
                    end
                    else
                    begin
                        nt = trk_reg + 7'd1;
                        if (nt == d7) nt = nt + 7'd1;
                    end
                    if (nt == 7'd0)
                    begin
                        nd = 1'b0; nt = d7 + 7'd1;
                        if (wrap_reg) stop = 1'b1;
                        nw = 1'b1;
                    end
                    if (!stop && (nt[6] || nt > {1'b0, NT6}))
                    begin
                        nd = 1'b1; nt = d7 - 7'd1;
                        if (nw) stop = 1'b1;
                        nw = 1'b1;
                    end
                    if (!stop && (nt == 7'd0 || nt[6])) stop = 1'b1;
                end
                down_next = nd; wrap_next = nw; trk_next = nt;
                if (stop)
                begin
                    trk_next = d7; first_next = 1'b0; state_next = S_DIR;
                    op_next = OP_READ;
                end
                else
                    state_next = S_RD;
            end
            S_DIR:
            begin
                // final try on the directory track, move_reg tags the pass
                if (!t_ok)
                begin
                    out_next = pack_out(ST_NONE, '0, '0, '0, '0);
                    state_next = S_OUT;
                end
                else
                begin
                    op_next = OP_FIND; first_next = 1'b0; down_next = 1'b0;
                    wrap_next = 1'b1; sec_next = '0;
                    state_next = S_RD;
                    // mark: any further STEP must end the search
                    move_next = 7'h7F;
                end
            end
            S_OUT:
            begin
                out_next = out_reg; ov_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // after the directory try, a failed probe ends with status ST_NONE
        if (state_reg == S_STEP && !first_reg && move_reg == 7'h7F && trk_reg == d7)
        begin
            out_next = pack_out(ST_NONE, '0, '0, '0, '0);
            state_next = S_OUT;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

endmodule
